// ===== src/assert_macros.svh =====
// assertion macros used by the route table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(lbl, clock, rstn, prop, msg) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(lbl, clock, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clock, rstn, !(cond), msg)

`endif

// ===== src/lprt_pkg.sv =====
// types, codes and helpers of the route table
package lprt_pkg;

    localparam int ADDR_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W = 3;
    localparam int LEN_W     = 6;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOROUTE = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_LOCAL_IP        = 3'd0;
    localparam reg_idx_t REG_LOCAL_NETMASK   = 3'd1;
    localparam reg_idx_t REG_LOCAL_GATEWAY   = 3'd2;
    localparam reg_idx_t REG_LOCAL_DEVICE    = 3'd3;
    localparam reg_idx_t REG_LOOPBACK_DEVICE = 3'd4;
    localparam reg_idx_t REG_DEFAULT_GATEWAY = 3'd5;
    localparam reg_idx_t REG_DEFAULT_DEVICE  = 3'd6;

    localparam logic [7:0] LOOPBACK_NET = 8'd127;

    // prefix length of a mask: eight nibble counts, then their sum
    function automatic logic [LEN_W-1:0] ones_count(input logic [ADDR_W-1:0] v);
        logic [2:0]       nib [8];
        logic [LEN_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + LEN_W'(nib[i]);
        end
        return sum;
    endfunction

endpackage

// ===== src/longest_prefix_route_table.sv =====
// ipv4 route table with longest prefix lookup, top level
//
// One item at a time; busy is high from the accepting edge until the result
// cycle. An add shows its result (strobe done) as it leaves S_ADD. A
// lookup reads the stored routes one slot per cycle through a single memory
// read port feeding one masked compare, then passes S_DRAIN and S_RESOLVE
// before the result shows. Fill, the number of routes added so far, is at
// most ENTRIES. Slots fill in order and are never removed, so a fill count
// stands for the valid marks and no clearing pass runs after reset.
// The result is on the ports for exactly one cycle and cannot be held off.
// Configuration writes are taken at any edge with wr_en high.
`include "assert_macros.svh"

module longest_prefix_route_table #(
    parameter int ENTRIES        = 16,
    parameter int DEVICE_ID_BITS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [31:0]                    address,
    input  logic [31:0]                    mask,
    input  logic [31:0]                    gateway,
    input  logic [DEVICE_ID_BITS-1:0]      device,
    input  logic                           wr_en,
    input  lprt_pkg::reg_idx_t             wr_index,
    input  logic [lprt_pkg::CFG_DATA_W-1:0] wr_data,
    output logic                           done,
    output lprt_pkg::status_t              status,
    output logic [DEVICE_ID_BITS-1:0]      out_device,
    output logic [31:0]                    next_hop,
    output logic                           is_local,
    output logic                           via_gateway
);

    import lprt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int DEV_W = DEVICE_ID_BITS;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DRAIN,
        S_RESOLVE
    } state_t;

    // route memory
    logic [ADDR_W-1:0] mem_network [ENTRIES];
    logic [ADDR_W-1:0] mem_mask    [ENTRIES];
    logic [ADDR_W-1:0] mem_gateway [ENTRIES];
    logic [DEV_W-1:0]  mem_device  [ENTRIES];
    logic [LEN_W-1:0]  mem_len     [ENTRIES];

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0] rd_network_reg;
    logic [ADDR_W-1:0] rd_mask_reg;
    logic [ADDR_W-1:0] rd_gateway_reg;
    logic [DEV_W-1:0]  rd_device_reg;
    logic [LEN_W-1:0]  rd_len_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_vld_reg, rd_vld_next;

    logic              kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] mask_reg, mask_next;
    logic [ADDR_W-1:0] gw_reg, gw_next;
    logic [DEV_W-1:0]  dev_reg, dev_next;

    logic              found_reg, found_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic [ADDR_W-1:0] best_gw_reg, best_gw_next;
    logic [DEV_W-1:0]  best_dev_reg, best_dev_next;

    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [DEV_W-1:0]  out_dev_reg, out_dev_next;
    logic [ADDR_W-1:0] hop_reg, hop_next;
    logic              local_reg, local_next;

    logic [ADDR_W-1:0] local_ip_reg, local_ip_next;
    logic [ADDR_W-1:0] local_netmask_reg, local_netmask_next;
    logic [ADDR_W-1:0] local_gateway_reg, local_gateway_next;
    logic [DEV_W-1:0]  local_device_reg, local_device_next;
    logic [DEV_W-1:0]  loopback_device_reg, loopback_device_next;
    logic [ADDR_W-1:0] default_gateway_reg, default_gateway_next;
    logic [DEV_W-1:0]  default_device_reg, default_device_next;

    logic              hit;
    logic              on_subnet;

    assign mem_raddr = issue_reg[IDX_W-1:0];
    assign mem_waddr = fill_reg[IDX_W-1:0];
    assign hit       = ((addr_reg & rd_mask_reg) == rd_network_reg);
    assign on_subnet = (((addr_reg ^ local_ip_reg) & local_netmask_reg) == '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_network[mem_waddr] <= addr_reg;
            mem_mask[mem_waddr]    <= mask_reg;
            mem_gateway[mem_waddr] <= gw_reg;
            mem_device[mem_waddr]  <= dev_reg;
            mem_len[mem_waddr]     <= ones_count(mask_reg);
        end
        rd_network_reg <= mem_network[mem_raddr];
        rd_mask_reg    <= mem_mask[mem_raddr];
        rd_gateway_reg <= mem_gateway[mem_raddr];
        rd_device_reg  <= mem_device[mem_raddr];
        rd_len_reg     <= mem_len[mem_raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        issue_next    = issue_reg;
        rd_vld_next   = 1'b0;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        mask_next     = mask_reg;
        gw_next       = gw_reg;
        dev_next      = dev_reg;
        found_next    = found_reg;
        best_len_next = best_len_reg;
        best_gw_next  = best_gw_reg;
        best_dev_next = best_dev_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        out_dev_next  = out_dev_reg;
        hop_next      = hop_reg;
        local_next    = local_reg;
        mem_we        = 1'b0;

        local_ip_next        = local_ip_reg;
        local_netmask_next   = local_netmask_reg;
        local_gateway_next   = local_gateway_reg;
        local_device_next    = local_device_reg;
        loopback_device_next = loopback_device_reg;
        default_gateway_next = default_gateway_reg;
        default_device_next  = default_device_reg;

        if (wr_en)
        begin
            case (wr_index)
                REG_LOCAL_IP:        local_ip_next        = wr_data;
                REG_LOCAL_NETMASK:   local_netmask_next   = wr_data;
                REG_LOCAL_GATEWAY:   local_gateway_next   = wr_data;
                REG_LOCAL_DEVICE:    local_device_next    = wr_data[DEV_W-1:0];
                REG_LOOPBACK_DEVICE: loopback_device_next = wr_data[DEV_W-1:0];
                REG_DEFAULT_GATEWAY: default_gateway_next = wr_data;
                REG_DEFAULT_DEVICE:  default_device_next  = wr_data[DEV_W-1:0];
                default:             ;
            endcase
        end

        // compare stage for the slot read in the previous cycle
        if (rd_vld_reg && hit && (!found_reg || rd_len_reg >= best_len_reg))
        begin
            found_next    = 1'b1;
            best_len_next = rd_len_reg;
            best_gw_next  = rd_gateway_reg;
            best_dev_next = rd_device_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    addr_next  = address;
                    mask_next  = mask;
                    gw_next    = gateway;
                    dev_next   = device;
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = kind ? S_ADD : S_SCAN;
                end
            end
            S_ADD:
            begin
                done_next    = 1'b1;
                out_dev_next = '0;
                hop_next     = '0;
                local_next   = 1'b0;
                if (fill_reg != FULL_COUNT)
                begin
                    mem_we      = 1'b1;
                    fill_next   = fill_reg + 1'b1;
                    status_next = ST_OK;
                end
                else
                begin
                    status_next = ST_FULL;
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (issue_reg != fill_reg)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                done_next    = 1'b1;
                status_next  = ST_OK;
                out_dev_next = '0;
                hop_next     = '0;
                local_next   = 1'b0;
                if (addr_reg[31:24] == LOOPBACK_NET)
                begin
                    if (loopback_device_reg != '0)
                    begin
                        out_dev_next = loopback_device_reg;
                        local_next   = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_NOROUTE;
                    end
                end
                else if (local_device_reg != '0 && addr_reg == local_ip_reg)
                begin
                    out_dev_next = local_device_reg;
                    local_next   = 1'b1;
                end
                else if (found_reg)
                begin
                    out_dev_next = best_dev_reg;
                    hop_next     = best_gw_reg;
                end
                else if (default_device_reg != '0)
                begin
                    out_dev_next = default_device_reg;
                    hop_next     = default_gateway_reg;
                end
                else if (local_device_reg != '0)
                begin
                    out_dev_next = local_device_reg;
                    hop_next     = on_subnet ? '0 : local_gateway_reg;
                end
                else
                begin
                    status_next = ST_NOROUTE;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            fill_reg            <= '0;
            issue_reg           <= '0;
            rd_vld_reg          <= 1'b0;
            kind_reg            <= 1'b0;
            addr_reg            <= '0;
            mask_reg            <= '0;
            gw_reg              <= '0;
            dev_reg             <= '0;
            found_reg           <= 1'b0;
            best_len_reg        <= '0;
            best_gw_reg         <= '0;
            best_dev_reg        <= '0;
            done_reg            <= 1'b0;
            status_reg          <= ST_OK;
            out_dev_reg         <= '0;
            hop_reg             <= '0;
            local_reg           <= 1'b0;
            local_ip_reg        <= '0;
            local_netmask_reg   <= '0;
            local_gateway_reg   <= '0;
            local_device_reg    <= '0;
            loopback_device_reg <= '0;
            default_gateway_reg <= '0;
            default_device_reg  <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            fill_reg            <= fill_next;
            issue_reg           <= issue_next;
            rd_vld_reg          <= rd_vld_next;
            kind_reg            <= kind_next;
            addr_reg            <= addr_next;
            mask_reg            <= mask_next;
            gw_reg              <= gw_next;
            dev_reg             <= dev_next;
            found_reg           <= found_next;
            best_len_reg        <= best_len_next;
            best_gw_reg         <= best_gw_next;
            best_dev_reg        <= best_dev_next;
            done_reg            <= done_next;
            status_reg          <= status_next;
            out_dev_reg         <= out_dev_next;
            hop_reg             <= hop_next;
            local_reg           <= local_next;
            local_ip_reg        <= local_ip_next;
            local_netmask_reg   <= local_netmask_next;
            local_gateway_reg   <= local_gateway_next;
            local_device_reg    <= local_device_next;
            loopback_device_reg <= loopback_device_next;
            default_gateway_reg <= default_gateway_next;
            default_device_reg  <= default_device_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_device  = out_dev_reg;
    assign next_hop    = hop_reg;
    assign is_local    = local_reg;
    assign via_gateway = (hop_reg != '0);

    `ASSERT_CLK(a_done_after_busy, clk, rst_n, done |-> $past(busy), "result without a busy item")
    `ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_reg > FULL_COUNT, "fill count beyond table size")
    `ASSERT_NEVER(a_issue_bound, clk, rst_n, issue_reg > fill_reg, "scan ran past filled slots")
    `ASSERT_CLK(a_full_only_when_full, clk, rst_n, (done && status == ST_FULL) |-> (fill_reg == FULL_COUNT), "table full reported with free slots")
    `ASSERT_CLK(a_add_counts, clk, rst_n, (state_reg == S_ADD && fill_reg != FULL_COUNT) |=> (fill_reg == $past(fill_reg) + 1'b1), "add did not take a slot")

endmodule

// ===== sim/testbench.sv =====
// route table testbench: directed and random adds and lookups checked against a predictor
module testbench;
    import lprt_pkg::*;

    localparam int ENTRIES        = 16;
    localparam int DEVICE_ID_BITS = 4;
    localparam logic KIND_LOOKUP  = 1'b0;
    localparam logic KIND_ADD     = 1'b1;
    localparam int CFG_RANDOM     = 0;
    localparam int CFG_ONES       = 1;
    localparam int CFG_ZEROS      = 2;

    typedef struct packed {
        status_t                   status;
        logic [DEVICE_ID_BITS-1:0] out_device;
        logic [31:0]               next_hop;
        logic                      is_local;
        logic                      via_gateway;
    } route_result_t;

    class route_scoreboard;
        bit [31:0]               host_ip;
        bit [31:0]               host_mask;
        bit [31:0]               host_gateway;
        bit [DEVICE_ID_BITS-1:0] host_dev;
        bit [DEVICE_ID_BITS-1:0] loop_dev;
        bit [31:0]               dflt_gateway;
        bit [DEVICE_ID_BITS-1:0] dflt_dev;
        bit [31:0]               net [ENTRIES];
        bit [31:0]               msk [ENTRIES];
        bit [31:0]               gw [ENTRIES];
        bit [DEVICE_ID_BITS-1:0] dev [ENTRIES];
        int                      used = 0;
        int                      errors = 0;
        route_result_t           pending_routes [$];

        function void write_reg(reg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_LOCAL_IP:        host_ip = data;
                REG_LOCAL_NETMASK:   host_mask = data;
                REG_LOCAL_GATEWAY:   host_gateway = data;
                REG_LOCAL_DEVICE:    host_dev = data[DEVICE_ID_BITS-1:0];
                REG_LOOPBACK_DEVICE: loop_dev = data[DEVICE_ID_BITS-1:0];
                REG_DEFAULT_GATEWAY: dflt_gateway = data;
                REG_DEFAULT_DEVICE:  dflt_dev = data[DEVICE_ID_BITS-1:0];
                default: ;
            endcase
        endfunction

        // work out the route of an accepted item and queue it
        function void note_item(logic k, logic [31:0] a, logic [31:0] m, logic [31:0] g,
                                logic [DEVICE_ID_BITS-1:0] d);
            route_result_t r;
            int best;
            int best_len;
            r = '0;
            r.status = ST_OK;
            best = -1;
            best_len = 0;
            if (k == KIND_ADD)
            begin
                if (used < ENTRIES)
                begin
                    net[used] = a;
                    msk[used] = m;
                    gw[used] = g;
                    dev[used] = d;
                    used++;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            else if (a[31:24] == LOOPBACK_NET)
            begin
                if (loop_dev != 0)
                begin
                    r.out_device = loop_dev;
                    r.is_local = 1'b1;
                end
                else
                begin
                    r.status = ST_NOROUTE;
                end
            end
            else if (host_dev != 0 && a == host_ip)
            begin
                r.out_device = host_dev;
                r.is_local = 1'b1;
            end
            else
            begin
                for (int i = 0; i < used; i++)
                begin
                    if ((a & msk[i]) == net[i] && (best < 0 || $countones(msk[i]) >= best_len))
                    begin
                        best = i;
                        best_len = $countones(msk[i]);
                    end
                end
                if (best >= 0)
                begin
                    r.out_device = dev[best];
                    r.next_hop = gw[best];
                end
                else if (dflt_dev != 0)
                begin
                    r.out_device = dflt_dev;
                    r.next_hop = dflt_gateway;
                end
                else if (host_dev != 0)
                begin
                    r.out_device = host_dev;
                    if ((a & host_mask) != (host_ip & host_mask))
                    begin
                        r.next_hop = host_gateway;
                    end
                end
                else
                begin
                    r.status = ST_NOROUTE;
                end
                r.via_gateway = (r.next_hop != 0);
            end
            pending_routes.push_back(r);
        endfunction

        function void check_result(route_result_t got);
            route_result_t want;
            if (pending_routes.size() == 0)
            begin
                $display("%0t: result with no item pending, status %0d", $time, got.status);
                errors++;
                return;
            end
            want = pending_routes.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.out_device !== want.out_device)
            begin
                $display("%0t: out_device expected %0d got %0d", $time,
                         want.out_device, got.out_device);
                errors++;
            end
            if (got.next_hop !== want.next_hop)
            begin
                $display("%0t: next_hop expected %h got %h", $time, want.next_hop, got.next_hop);
                errors++;
            end
            if (got.is_local !== want.is_local)
            begin
                $display("%0t: is_local expected %b got %b", $time, want.is_local, got.is_local);
                errors++;
            end
            if (got.via_gateway !== want.via_gateway)
            begin
                $display("%0t: via_gateway expected %b got %b", $time,
                         want.via_gateway, got.via_gateway);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      kind;
    logic [31:0]               address;
    logic [31:0]               mask;
    logic [31:0]               gateway;
    logic [DEVICE_ID_BITS-1:0] device;
    logic                      wr_en;
    reg_idx_t                  wr_index;
    logic [CFG_DATA_W-1:0]     wr_data;
    logic                      done;
    status_t                   status;
    logic [DEVICE_ID_BITS-1:0] out_device;
    logic [31:0]               next_hop;
    logic                      is_local;
    logic                      via_gateway;

    route_scoreboard sb = new;

    longest_prefix_route_table #(
        .ENTRIES        (ENTRIES),
        .DEVICE_ID_BITS (DEVICE_ID_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .address     (address),
        .mask        (mask),
        .gateway     (gateway),
        .device      (device),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .done        (done),
        .status      (status),
        .out_device  (out_device),
        .next_hop    (next_hop),
        .is_local    (is_local),
        .via_gateway (via_gateway)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            sb.check_result('{status, out_device, next_hop, is_local, via_gateway});
        end
    end

    // start stays high on return so a burst can follow at the same edge
    task send_item(input logic k, input logic [31:0] a, input logic [31:0] m,
                   input logic [31:0] g, input logic [DEVICE_ID_BITS-1:0] d);
        start <= 1'b1;
        kind <= k;
        address <= a;
        mask <= m;
        gateway <= g;
        device <= d;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        sb.note_item(k, a, m, g, d);
    endtask

    task lookup(input logic [31:0] a);
        send_item(KIND_LOOKUP, a, $urandom, $urandom, DEVICE_ID_BITS'($urandom));
    endtask

    task wait_idle;
        start <= 1'b0;
        while (sb.pending_routes.size() != 0 || busy !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    task write_cfg(input reg_idx_t idx, input logic [31:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task reconfigure(input int style);
        logic [31:0] v;
        int k;
        for (int i = 0; i <= REG_DEFAULT_DEVICE; i++)
        begin
            if (style != CFG_RANDOM || $urandom_range(0, 2) != 0)
            begin
                case (reg_idx_t'(i))
                    REG_LOCAL_IP:
                    begin
                        v = pick_word();
                        if (sb.used > 0 && $urandom_range(0, 2) == 0)
                        begin
                            k = $urandom_range(0, sb.used - 1);
                            v = (sb.net[k] & sb.msk[k]) | ($urandom & ~sb.msk[k]);
                        end
                    end
                    REG_LOCAL_NETMASK:
                    begin
                        v = $urandom_range(0, 3) == 0 ? pick_word()
                            : 32'hFFFF_FFFF << $urandom_range(0, 32);
                    end
                    REG_LOCAL_DEVICE, REG_LOOPBACK_DEVICE, REG_DEFAULT_DEVICE:
                    begin
                        v = $urandom_range(0, 3) == 0 ? 32'h0 : $urandom;
                    end
                    default:
                    begin
                        v = pick_word();
                    end
                endcase
                if (style == CFG_ONES)
                begin
                    v = 32'hFFFF_FFFF;
                end
                else if (style == CFG_ZEROS)
                begin
                    v = 32'h0;
                end
                write_cfg(reg_idx_t'(i), v);
            end
        end
        wr_en <= 1'b0;
    endtask

    task random_route;
        int len;
        int k;
        logic [31:0] m;
        logic [31:0] n;
        len = $urandom_range(0, 32);
        m = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
        if ($urandom_range(0, 7) == 0)
        begin
            m = $urandom;
        end
        if (sb.used > 0 && $urandom_range(0, 2) == 0)
        begin
            // nest under a stored route
            k = $urandom_range(0, sb.used - 1);
            n = ((sb.net[k] & sb.msk[k]) | $urandom) & m;
        end
        else
        begin
            n = $urandom & m;
        end
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom;
        end
        // the catch-all route is kept for the last slot
        if (m == 0 && n == 0)
        begin
            n = 32'h1;
        end
        send_item(KIND_ADD, n, m, $urandom_range(0, 1) ? 32'h0 : $urandom,
                  DEVICE_ID_BITS'($urandom));
    endtask

    task random_item;
        int k;
        logic [31:0] a;
        if ($urandom_range(0, 99) == 0 && sb.used < ENTRIES - 1)
        begin
            random_route();
        end
        else
        begin
            k = sb.used > 0 ? $urandom_range(0, sb.used - 1) : 0;
            case ($urandom_range(0, 9))
                0: a = $urandom;
                1: a = {LOOPBACK_NET, 24'($urandom)};
                2: a = sb.host_ip;
                3: a = (sb.host_ip & sb.host_mask) | ($urandom & ~sb.host_mask);
                9: a = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
                default:
                begin
                    a = (sb.net[k] & sb.msk[k]) | ($urandom & ~sb.msk[k]);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        a = a ^ (32'h1 << $urandom_range(0, 31));
                    end
                end
            endcase
            lookup(a);
        end
    endtask

    task run_phase(input int count, input bit fill_up);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                if (gap > 0 && n > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            if (fill_up && $urandom_range(0, 3) == 0)
            begin
                random_route();
            end
            else
            begin
                random_item();
            end
            burst--;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        kind <= KIND_LOOKUP;
        address <= '0;
        mask <= '0;
        gateway <= '0;
        device <= '0;
        wr_en <= 1'b0;
        wr_index <= REG_LOCAL_IP;
        wr_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, nothing configured
        lookup(32'h0000_0000);
        lookup(32'h7F00_0001);
        lookup(32'hFFFF_FFFF);
        wait_idle();

        write_cfg(REG_LOOPBACK_DEVICE, 32'hFFFF_FFF3);
        write_cfg(REG_LOCAL_IP, 32'h0A00_0005);
        write_cfg(REG_LOCAL_NETMASK, 32'hFFFF_FF00);
        write_cfg(REG_LOCAL_GATEWAY, 32'h0A00_00FE);
        write_cfg(REG_LOCAL_DEVICE, 32'h0000_0002);
        wr_en <= 1'b0;
        lookup(32'h7FFF_FFFF);
        lookup(32'h0A00_0005);
        lookup(32'h0A00_0077);
        lookup(32'h0808_0808);

        send_item(KIND_ADD, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0, 4'd5);
        send_item(KIND_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 4'd6);
        // same prefix again, the later slot must win
        send_item(KIND_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0, 4'd7);
        // host bits outside the mask, never matches
        send_item(KIND_ADD, 32'h0A01_00FF, 32'hFFFF_0000, 32'h0A01_0001, 4'd8);
        send_item(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
        send_item(KIND_ADD, 32'h0A00_0005, 32'hFFFF_FFFF, 32'h0, 4'd9);
        lookup(32'hC0A8_0133);
        lookup(32'hC0A8_0233);
        lookup(32'h0A01_00FF);
        lookup(32'hFFFF_FFFF);
        lookup(32'h0A00_0005);
        wait_idle();

        write_cfg(REG_DEFAULT_GATEWAY, 32'h0);
        write_cfg(REG_DEFAULT_DEVICE, 32'hFFFF_FFFF);
        wr_en <= 1'b0;
        lookup(32'h0808_0808);
        wait_idle();
        write_cfg(REG_DEFAULT_GATEWAY, 32'hFFFF_FFFF);
        wr_en <= 1'b0;
        lookup(32'h0102_0304);
        wait_idle();

        for (int p = 0; p < 12; p++)
        begin
            reconfigure(p == 0 ? CFG_ONES : (p == 1 ? CFG_ZEROS : CFG_RANDOM));
            run_phase(150, 1'b0);
        end

        // fill the table, add the catch-all route last, then overflow it
        reconfigure(CFG_RANDOM);
        while (sb.used < ENTRIES - 1)
        begin
            random_route();
        end
        send_item(KIND_ADD, 32'h0, 32'h0, $urandom, DEVICE_ID_BITS'($urandom));
        run_phase(40, 1'b1);

        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending_routes.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #(12 * 600000);
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
